// ----- design/sfd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package sfd_pkg;
   localparam int unsigned DataWidth = 32;
   localparam int unsigned FmtWidth  = 3;

   localparam logic [FmtWidth-1:0] FMT_HALF = 3'd0;
   localparam logic [FmtWidth-1:0] FMT_BF16 = 3'd1;
   localparam logic [FmtWidth-1:0] FMT_E4M3 = 3'd2;
   localparam logic [FmtWidth-1:0] FMT_E5M2 = 3'd3;
   localparam logic [FmtWidth-1:0] FMT_FP32 = 3'd4;

   localparam logic [31:0] FP32_INF  = 32'h7F80_0000;
   localparam logic [31:0] FP32_QNAN = 32'h7FC0_0000;

   localparam logic [1:0] CSR_ADDR_FORMAT = 2'd0;
endpackage
`default_nettype wire

// ----- design/sfd_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface sfd_stream_if #(parameter int unsigned Width = 32);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/sfd_convert.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sfd_convert import sfd_pkg::*; (
   input  wire logic [FmtWidth-1:0]  format,
   input  wire logic [DataWidth-1:0] raw_bits,
   output logic      [DataWidth-1:0] fp32_bits
);
   logic [31:0] half_r, e4_r, e5_r;
   logic [3:0]  lz;
   logic [9:0]  hm;
   logic [4:0]  he;

   // Binary16: subnormal mantissa normalized by leading-one position.
   always_comb begin
      he = raw_bits[14:10];
      hm = raw_bits[9:0];
      lz = 4'd0;
      for (int i = 0; i <= 9; i++) begin
         if (hm[i]) lz = 4'(9 - i);
      end
      if (he == 5'h1F) begin
         half_r = {raw_bits[15], 8'hFF, hm, 13'd0};
      end else if (he != 5'd0) begin
         half_r = {raw_bits[15], 8'(he + 8'd112), hm, 13'd0};
      end else if (hm == 10'd0) begin
         half_r = {raw_bits[15], 31'd0};
      end else begin
         half_r = {raw_bits[15], 8'(8'd112 - 8'(lz)), 10'(hm << (lz + 4'd1)), 13'd0};
      end
   end

   // E4M3FN, bias 7.
   always_comb begin
      if (raw_bits[6:0] == 7'h7F) begin
         e4_r = FP32_QNAN | {raw_bits[7], 31'd0};
      end else if (raw_bits[6:3] != 4'd0) begin
         e4_r = {raw_bits[7], 8'(raw_bits[6:3] + 8'd120), raw_bits[2:0], 20'd0};
      end else if (raw_bits[2]) begin
         e4_r = {raw_bits[7], 8'd120, raw_bits[1:0], 21'd0};
      end else if (raw_bits[1]) begin
         e4_r = {raw_bits[7], 8'd119, raw_bits[0], 22'd0};
      end else if (raw_bits[0]) begin
         e4_r = {raw_bits[7], 8'd118, 23'd0};
      end else begin
         e4_r = {raw_bits[7], 31'd0};
      end
   end

   // E5M2, bias 15.
   always_comb begin
      if (raw_bits[6:2] == 5'h1F) begin
         e5_r = ((raw_bits[1:0] == 2'd0) ? FP32_INF : FP32_QNAN) | {raw_bits[7], 31'd0};
      end else if (raw_bits[6:2] != 5'd0) begin
         e5_r = {raw_bits[7], 8'(raw_bits[6:2] + 8'd112), raw_bits[1:0], 21'd0};
      end else if (raw_bits[1]) begin
         e5_r = {raw_bits[7], 8'd112, raw_bits[0], 22'd0};
      end else if (raw_bits[0]) begin
         e5_r = {raw_bits[7], 8'd111, 23'd0};
      end else begin
         e5_r = {raw_bits[7], 31'd0};
      end
   end

   always_comb begin
      case (format)
         FMT_HALF: fp32_bits = half_r;
         FMT_BF16: fp32_bits = {raw_bits[15:0], 16'd0};
         FMT_E4M3: fp32_bits = e4_r;
         FMT_E5M2: fp32_bits = e5_r;
         FMT_FP32: fp32_bits = raw_bits;
         default:  fp32_bits = FP32_QNAN;
      endcase
   end
endmodule
`default_nettype wire

// ----- design/small_float_to_fp32_decoder_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Converts one raw element per transfer into its IEEE binary32 bit pattern.
// The source format (binary16, bfloat16, FP8 E4M3FN, FP8 E5M2 or binary32)
// comes from the source_format register at CSR address 0; undefined codes
// give the quiet NaN 0x7FC00000. Each item is registered at the input, decoded
// by a single combinational stage, and held in a result register, so one
// transfer is accepted every cycle while the output is not stalled. The input
// stays ready while the result register drains or is simply refilled.
module small_float_to_fp32_decoder_unit import sfd_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   sfd_stream_if.sink      req,
   sfd_stream_if.source    rsp,
   input  wire logic       csr_psel,
   input  wire logic       csr_penable,
   input  wire logic       csr_pwrite,
   input  wire logic [1:0] csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]     csr_prdata,
   output logic            csr_pready
);
   logic [FmtWidth-1:0]  format_ff, format_in;
   logic                 in_valid_ff, out_valid_ff;
   logic [DataWidth-1:0] in_data_ff, out_data_ff, conv;
   logic                 adv_out, adv_in;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_ADDR_FORMAT) ? {29'd0, format_ff} : 32'd0;

   always_comb begin
      format_in = format_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_ADDR_FORMAT) begin
         format_in = csr_pwdata[FmtWidth-1:0];
      end
   end

   // The result register takes a new value when empty or being drained.
   assign adv_out = !out_valid_ff || rsp.ready;
   // The input register moves on whenever its content can go forward.
   assign adv_in  = !in_valid_ff || adv_out;
   assign req.ready = adv_in;

   sfd_convert u_convert (
      .format    (format_ff),
      .raw_bits  (in_data_ff),
      .fp32_bits (conv)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff    <= FMT_HALF;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         format_ff <= format_in;
         if (adv_in) in_valid_ff <= req.valid;
         if (adv_out) out_valid_ff <= in_valid_ff;
      end
      if (adv_in && req.valid) in_data_ff <= req.data;
      if (adv_out && in_valid_ff) out_data_ff <= conv;
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_data_ff;

   // A stalled result must not change.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("result changed while stalled");
   // A staged item moves into the result register when it can.
   a_move: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && adv_out |=> out_valid_ff)
      else $error("staged item lost");
   // Input is refused only when both stages are full.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> in_valid_ff && out_valid_ff)
      else $error("input refused with room");
endmodule
`default_nettype wire
